>>> rtl/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// shared types and codes of the setpoint sweep sequencer
// ----------------------------------------------------------------------------
package ssw_pkg;

   // fixed field widths
   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int MEAS_W  = 26;
   localparam int CFG_W   = 24;
   localparam int IDX_W   = 3;
   localparam int REP_W   = 16;
   localparam int PASS_W  = 17;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = OP_W + KIND_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_START   = 2'd0;
   localparam logic [OP_W-1:0] OP_ESTOP   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
   localparam logic [OP_W-1:0] OP_MEASURE = 2'd3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_START_VALUE   = 3'd0;
   localparam logic [IDX_W-1:0] REG_END_VALUE     = 3'd1;
   localparam logic [IDX_W-1:0] REG_STEP_SIZE     = 3'd2;
   localparam logic [IDX_W-1:0] REG_REPEAT_COUNT  = 3'd3;
   localparam logic [IDX_W-1:0] REG_TRIANGLE_MODE = 3'd4;
   localparam logic [IDX_W-1:0] REG_USE_COMPUTED  = 3'd5;
   localparam logic [IDX_W-1:0] REG_ZERO_FINISHED = 3'd6;
   localparam logic [IDX_W-1:0] REG_TARGET_KIND   = 3'd7;

   typedef struct packed {
      logic [CFG_W-1:0] start_value;
      logic [CFG_W-1:0] end_value;
      logic [CFG_W-1:0] step_size;
      logic [REP_W-1:0] repeat_count;
      logic             triangle_mode;
      logic             use_computed;
      logic             zero_when_finished;
      logic             target_kind;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic setpoint_kind;
      logic sweep_done;
      logic is_emergency;
   } rsp_flags_type;

endpackage

>>> rtl/ssw_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_csr
// configuration register file, write only
// ----------------------------------------------------------------------------
module ssw_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [ssw_pkg::IDX_W-1:0]  csr_index,
   input  logic [ssw_pkg::CFG_W-1:0]  csr_wdata,
   output ssw_pkg::cfg_type           cfg
);
   import ssw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_START_VALUE:   cfg_in.start_value        = csr_wdata;
            REG_END_VALUE:     cfg_in.end_value          = csr_wdata;
            REG_STEP_SIZE:     cfg_in.step_size          = csr_wdata;
            REG_REPEAT_COUNT:  cfg_in.repeat_count       = csr_wdata[REP_W-1:0];
            REG_TRIANGLE_MODE: cfg_in.triangle_mode      = csr_wdata[0];
            REG_USE_COMPUTED:  cfg_in.use_computed       = csr_wdata[0];
            REG_ZERO_FINISHED: cfg_in.zero_when_finished = csr_wdata[0];
            REG_TARGET_KIND:   cfg_in.target_kind        = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_value:        '0,
                     end_value:          '0,
                     step_size:          CFG_W'(1),
                     repeat_count:       '0,
                     triangle_mode:      1'b0,
                     use_computed:       1'b1,
                     zero_when_finished: 1'b0,
                     target_kind:        1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/ssw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_step
// sweep state registers and the combinational step logic for one beat
// ----------------------------------------------------------------------------
module ssw_step #(
   parameter int VALUE_WIDTH = 26
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [ssw_pkg::OP_W-1:0]    op,
   input  logic [ssw_pkg::KIND_W-1:0]  measured_kind,
   input  logic [ssw_pkg::MEAS_W-1:0]  measured_value,
   input  ssw_pkg::cfg_type            cfg,
   output logic [VALUE_WIDTH-1:0]      res_setpoint,
   output ssw_pkg::rsp_flags_type      res_flags,
   output logic                        running
);
   import ssw_pkg::*;

   // wide enough for a register +/- step and for any measured value
   localparam int EW = ((VALUE_WIDTH > CFG_W + 1) ? VALUE_WIDTH : CFG_W + 1) + 1;
   localparam logic signed [EW-1:0] VMAX_E = (EW'(1) <<< (VALUE_WIDTH - 1)) - EW'(1);
   localparam logic signed [EW-1:0] VMIN_E = -VMAX_E - EW'(1);

   function automatic logic [VALUE_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = v;
      if (v > VMAX_E) r = VMAX_E;
      if (v < VMIN_E) r = VMIN_E;
      return r[VALUE_WIDTH-1:0];
   endfunction

   logic                   running_ff, running_in;
   logic                   rising_ff, rising_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] last_ff, last_in;
   logic [PASS_W-1:0]      pass_ff, pass_in;

   logic signed [EW-1:0]   start_e, end_e, step_e, lo_e, hi_e, cur_e, base_e;
   logic                   ordered, at_edge, pass_below, edge_wrap, tick_rising;
   logic [PASS_W-1:0]      limit;
   logic [VALUE_WIDTH-1:0] preset_start, preset_keep, tick_cur, tick_last, base, step_sp;
   logic [VALUE_WIDTH-1:0] meas_sat;

   always_comb begin
      start_e = signed'(EW'(cfg.start_value));
      end_e   = signed'(EW'(cfg.end_value));
      step_e  = signed'(EW'(cfg.step_size));
      ordered = (cfg.start_value <= cfg.end_value);
      lo_e    = ordered ? start_e : end_e;
      hi_e    = ordered ? end_e : start_e;
      cur_e   = EW'(signed'(cur_ff));

      preset_start = sat(ordered   ? start_e - step_e : start_e + step_e);
      preset_keep  = sat(rising_ff ? start_e - step_e : start_e + step_e);

      at_edge = rising_ff ? (cur_e >= hi_e) : (cur_e <= lo_e);
      limit   = PASS_W'(cfg.triangle_mode)
              + (cfg.triangle_mode ? {cfg.repeat_count, 1'b0} : {1'b0, cfg.repeat_count});
      pass_below = (pass_ff < limit);
      edge_wrap  = at_edge && pass_below;

      // reverse in triangle mode, otherwise restart from the start value
      tick_rising = (edge_wrap && cfg.triangle_mode) ? !rising_ff : rising_ff;
      tick_cur    = (edge_wrap && !cfg.triangle_mode) ? preset_keep : cur_ff;
      tick_last   = (edge_wrap && !cfg.triangle_mode) ? preset_keep : last_ff;
      base        = cfg.use_computed ? tick_cur : tick_last;
      base_e      = EW'(signed'(base));
      step_sp     = sat(tick_rising ? base_e + step_e : base_e - step_e);

      meas_sat = sat(EW'(signed'(measured_value)));
   end

   always_comb begin
      running_in = running_ff;
      rising_in  = rising_ff;
      cur_in     = cur_ff;
      last_in    = last_ff;
      pass_in    = pass_ff;
      res_setpoint            = '0;
      res_flags.valid         = 1'b0;
      res_flags.setpoint_kind = cfg.target_kind;
      res_flags.sweep_done    = 1'b0;
      res_flags.is_emergency  = 1'b0;
      case (op)
         OP_START: begin
            running_in = !running_ff;
            rising_in  = ordered;
            pass_in    = '0;
            cur_in     = preset_start;
            last_in    = preset_start;
         end
         OP_ESTOP: begin
            running_in             = 1'b0;
            res_flags.valid        = 1'b1;
            res_flags.is_emergency = 1'b1;
         end
         OP_MEASURE: begin
            if (measured_kind == {1'b0, cfg.target_kind}) begin
               last_in = meas_sat;
            end
         end
         OP_TICK: begin
            if (running_ff) begin
               if (at_edge && !pass_below) begin
                  // budget spent
                  running_in = 1'b0;
                  if (cfg.zero_when_finished) begin
                     res_flags.valid      = 1'b1;
                     res_flags.sweep_done = 1'b1;
                  end
               end else begin
                  rising_in       = tick_rising;
                  cur_in          = step_sp;
                  last_in         = tick_last;
                  pass_in         = edge_wrap ? pass_ff + PASS_W'(1) : pass_ff;
                  res_flags.valid = 1'b1;
                  res_setpoint    = step_sp;
               end
            end
         end
         default: begin
            running_in = running_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         rising_ff  <= 1'b1;
         cur_ff     <= '0;
         last_ff    <= '0;
         pass_ff    <= '0;
      end else if (enable) begin
         running_ff <= running_in;
         rising_ff  <= rising_in;
         cur_ff     <= cur_in;
         last_ff    <= last_in;
         pass_ff    <= pass_in;
      end
   end

   assign running = running_ff;

endmodule

>>> rtl/setpoint_sweep_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_sweep_sequencer
// staircase setpoint sweep generator with restart or triangle repeat
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one beat per command; req_tuser holds the operation (start,
//   emergency stop, tick, measurement) and the measurement kind, req_tdata
//   the measured value. start toggles the sweep and presets it one step
//   before the start value; ticks advance it; measurements update the value.
//   rsp_ channel: at most one beat per command; setpoint in rsp_tdata, kind
//   and emergency flag in rsp_tuser, rsp_tlast marks the beat ending a sweep.
//   csr_ port: plain write port, to be written only while the block is idle; the block does not check this.
// pipeline and throughput
//   a command is worked out while it sits in the input register and its
//   result is registered as it leaves. one command per cycle is accepted
//   while the result register drains; the step logic is combinational
//   between registers.
// reset and stall
//   synchronous reset clears the sweep (stopped, rising, setpoints zero) and
//   loads register defaults. when the receiver stalls, the result register
//   holds and one more command waits in the input register, then req_tready
//   falls until the result beat is taken.
// ----------------------------------------------------------------------------
module setpoint_sweep_sequencer #(
   parameter int VALUE_WIDTH = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // measured_value [25:0]
   input  logic [ssw_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation [1:0], measured_kind [3:2]
   input  logic [ssw_pkg::REQ_USER_W-1:0]    req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // setpoint [VALUE_WIDTH-1:0]
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]  rsp_tdata,
   // setpoint_kind [0], is_emergency [1]
   output logic [1:0]                        rsp_tuser,
   // sweep_done
   output logic                              rsp_tlast,
   // configuration write port
   input  logic                              csr_wr_en,
   input  logic [ssw_pkg::IDX_W-1:0]         csr_index,
   input  logic [ssw_pkg::CFG_W-1:0]         csr_wdata
);
   import ssw_pkg::*;

   localparam int RSP_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

   cfg_type                cfg;
   rsp_flags_type          res_flags;
   logic [VALUE_WIDTH-1:0] res_setpoint;
   logic                   running;

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]        s1_op_ff;
   logic [KIND_W-1:0]      s1_kind_ff;
   logic [MEAS_W-1:0]      s1_meas_ff;
   logic                   s1_advance;
   logic                   req_beat;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_sp_ff;
   logic                   rsp_kind_ff, rsp_done_ff, rsp_emg_ff;

   // command leaves the input register once the result slot is free
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = res_flags.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_op_ff   <= req_tuser[OP_W-1:0];
         s1_kind_ff <= req_tuser[OP_W+KIND_W-1:OP_W];
         s1_meas_ff <= req_tdata[MEAS_W-1:0];
      end
      if (s1_advance) begin
         rsp_sp_ff   <= res_setpoint;
         rsp_kind_ff <= res_flags.setpoint_kind;
         rsp_done_ff <= res_flags.sweep_done;
         rsp_emg_ff  <= res_flags.is_emergency;
      end
   end

   ssw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssw_step #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .enable         (s1_advance),
      .op             (s1_op_ff),
      .measured_kind  (s1_kind_ff),
      .measured_value (s1_meas_ff),
      .cfg            (cfg),
      .res_setpoint   (res_setpoint),
      .res_flags      (res_flags),
      .running        (running)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_sp_ff);
   assign rsp_tuser  = {rsp_emg_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_done_ff;

   // an emergency beat never ends a sweep as well
   a_emg_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[1] && rsp_tlast))
      else $error("emergency and sweep end flagged on one beat");

   // emergency stop always leaves the sweep stopped
   a_estop_stops: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_op_ff == OP_ESTOP) |=> !running)
      else $error("sweep still running after emergency stop");

   // back-pressure only when both registers are full and the receiver stalls
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled without a full pipeline");

endmodule
